// ----- src/rcfe_pkg.sv -----
// Shared constants and types of the RC channel frame encoder.
package rcfe_pkg;

  localparam int REG_COUNT = 8;
  localparam int REG_IDX_W = 3;
  localparam int AXIS_W = 8;
  localparam int VALUE_W = 16;
  localparam int CHAN_W = 11;
  localparam int BYTE_W = 8;
  localparam int CHANNEL_COUNT_DEF = 8;

  // Header layout: five fixed bytes ahead of the channel words.
  localparam int HDR_LEN = 5;
  localparam int POS_DOLLAR = 0;
  localparam int POS_M = 1;
  localparam int POS_DIR = 2;
  localparam int POS_SIZE = 3;
  localparam int POS_TYPE = 4;

  localparam logic [BYTE_W-1:0] CHAR_DOLLAR = 8'h24;
  localparam logic [BYTE_W-1:0] CHAR_M = 8'h4D;
  localparam logic [BYTE_W-1:0] CHAR_LT = 8'h3C;
  localparam logic [BYTE_W-1:0] FRAME_TYPE = 8'd200;

  localparam logic [CHAN_W-1:0] CENTRE_VALUE = 11'd1500;
  localparam logic [CHAN_W-1:0] BASE_VALUE = 11'd1000;
  localparam logic [9:0] SCALE_FACTOR = 10'd1000;

  // One channel update handed from the input register to the channel bank.
  typedef struct packed {
    logic en;
    logic [AXIS_W-1:0] axis;
    logic [VALUE_W-1:0] value;
  } upd_t;

endpackage

// ----- src/rcfe_chan_bank.sv -----
// Axis number registers, channel value registers and the position scaling.
module rcfe_chan_bank #(
  parameter int CHANNEL_COUNT = rcfe_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           cfg_we_i,
  input  logic [rcfe_pkg::REG_IDX_W-1:0]                 cfg_index_i,
  input  logic [rcfe_pkg::AXIS_W-1:0]                    cfg_data_i,
  input  rcfe_pkg::upd_t                                 upd_i,
  output logic [CHANNEL_COUNT-1:0][rcfe_pkg::CHAN_W-1:0] chan_o
);
  import rcfe_pkg::*;

  localparam int MATCH_N = (CHANNEL_COUNT < REG_COUNT) ? CHANNEL_COUNT : REG_COUNT;

  logic [REG_COUNT-1:0][AXIS_W-1:0]     axis_reg_q;
  logic [CHANNEL_COUNT-1:0][CHAN_W-1:0] chan_q;
  logic [CHANNEL_COUNT-1:0]             hit;
  logic [VALUE_W-1:0]                   offset;
  logic [VALUE_W+9:0]                   product;
  logic [CHAN_W-1:0]                    scaled;

  // Adding 32768 to a two's complement value only flips its top bit.
  assign offset = {~upd_i.value[VALUE_W-1], upd_i.value[VALUE_W-2:0]};
  assign product = offset * SCALE_FACTOR;
  assign scaled = BASE_VALUE + CHAN_W'(product[VALUE_W+9:VALUE_W]);

  // Only the lowest-numbered matching channel takes the update.
  always_comb begin
    logic found;
    found = 1'b0;
    hit = '0;
    for (int i = 0; i < MATCH_N; i++) begin
      if (!found && axis_reg_q[i] == upd_i.axis) begin
        hit[i] = 1'b1;
        found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < REG_COUNT; i++) begin
        axis_reg_q[i] <= AXIS_W'(i);
      end
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        chan_q[i] <= CENTRE_VALUE;
      end
    end else begin
      if (cfg_we_i) begin
        axis_reg_q[cfg_index_i] <= cfg_data_i;
      end
      if (upd_i.en) begin
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          if (hit[i]) begin
            chan_q[i] <= scaled;
          end
        end
      end
    end
  end

  assign chan_o = chan_q;

endmodule

// ----- src/rcfe_framer.sv -----
// Framer: header, channel bytes, running checksum; one byte per cycle while ready.
module rcfe_framer #(
  parameter int CHANNEL_COUNT = rcfe_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                                           clk_i,
  input  logic                                           rst_ni,
  input  logic                                           start_i,
  input  logic [CHANNEL_COUNT-1:0][rcfe_pkg::CHAN_W-1:0] chan_i,
  output logic                                           can_start_o,
  output logic                                           valid_o,
  input  logic                                           ready_i,
  output logic [rcfe_pkg::BYTE_W-1:0]                    byte_o,
  output logic                                           last_o
);
  import rcfe_pkg::*;

  localparam int FRAME_LEN = HDR_LEN + 2 * CHANNEL_COUNT + 1;
  localparam int IDX_W = $clog2(FRAME_LEN);
  localparam int CH_W = (CHANNEL_COUNT > 1) ? $clog2(CHANNEL_COUNT) : 1;
  localparam logic [IDX_W-1:0] I_DOLLAR = IDX_W'(POS_DOLLAR);
  localparam logic [IDX_W-1:0] I_M = IDX_W'(POS_M);
  localparam logic [IDX_W-1:0] I_DIR = IDX_W'(POS_DIR);
  localparam logic [IDX_W-1:0] I_SIZE = IDX_W'(POS_SIZE);
  localparam logic [IDX_W-1:0] I_TYPE = IDX_W'(POS_TYPE);
  localparam logic [IDX_W-1:0] I_LAST = IDX_W'(FRAME_LEN - 1);
  localparam logic [BYTE_W-1:0] SIZE_BYTE = BYTE_W'(2 * CHANNEL_COUNT);

  logic                busy_q, busy_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [BYTE_W-1:0]   sum_q, sum_d;
  logic                valid_q, valid_d;
  logic [BYTE_W-1:0]   byte_q, byte_d;
  logic                last_q, last_d;
  logic                load;
  logic [IDX_W-1:0]    ch_off;
  logic [CH_W-1:0]     ch_sel;
  logic [CHAN_W-1:0]   ch_word;
  logic [BYTE_W-1:0]   ch_byte;
  logic [BYTE_W-1:0]   next_byte;

  // In a frame, a byte enters the output register whenever it is free or drained.
  assign load = busy_q && (!valid_q || ready_i);
  assign can_start_o = !busy_q || (load && idx_q == I_LAST);

  assign ch_off = idx_q - IDX_W'(HDR_LEN);
  assign ch_sel = ch_off[CH_W:1];

  always_comb begin
    ch_word = CENTRE_VALUE;
    if (32'(ch_sel) < CHANNEL_COUNT) begin
      ch_word = chan_i[ch_sel];
    end
    ch_byte = ch_off[0] ? BYTE_W'(ch_word[CHAN_W-1:BYTE_W]) : ch_word[BYTE_W-1:0];
  end

  always_comb begin
    case (idx_q)
      I_DOLLAR: next_byte = CHAR_DOLLAR;
      I_M:      next_byte = CHAR_M;
      I_DIR:    next_byte = CHAR_LT;
      I_SIZE:   next_byte = SIZE_BYTE;
      I_TYPE:   next_byte = FRAME_TYPE;
      I_LAST:   next_byte = sum_q;
      default:  next_byte = ch_byte;
    endcase
  end

  always_comb begin
    busy_d = busy_q;
    idx_d = idx_q;
    sum_d = sum_q;
    valid_d = valid_q;
    byte_d = byte_q;
    last_d = last_q;
    if (valid_q && ready_i) begin
      valid_d = 1'b0;
    end
    if (load) begin
      valid_d = 1'b1;
      byte_d = next_byte;
      last_d = (idx_q == I_LAST);
      idx_d = idx_q + 1'b1;
      if (idx_q >= IDX_W'(HDR_LEN) && idx_q != I_LAST) begin
        sum_d = sum_q ^ ch_byte;
      end
      if (idx_q == I_LAST) begin
        busy_d = 1'b0;
      end
    end
    if (start_i) begin
      busy_d = 1'b1;
      idx_d = '0;
      sum_d = SIZE_BYTE ^ FRAME_TYPE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q <= '0;
      valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q <= idx_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign valid_o = valid_q;
  assign byte_o = byte_q;
  assign last_o = last_q;

endmodule

// ----- src/rc_channel_frame_encoder_unit.sv -----
// Top level of the RC channel frame encoder: input register, channel bank and framer.
//
// Each joystick axis event (axis number, signed 16-bit position) updates the first
// channel whose configured axis number matches, scaled to 1000..1999, and then
// produces one complete channel frame of 6 + 2*CHANNEL_COUNT bytes (22 at the
// default): '$', 'M', '<', size, type 200, the channels low byte first, and an XOR
// checksum flagged with tlast. The framer sends one byte per cycle while m_axis_tready
// is high; an event waits in the input register while the previous frame is being
// sent, and the next frame starts in the cycle after the previous checksum byte has
// entered the output register. Channels reset to 1500 and axis registers to their
// own index; write them only while idle.
module rc_channel_frame_encoder_unit #(
  parameter int CHANNEL_COUNT = rcfe_pkg::CHANNEL_COUNT_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [rcfe_pkg::REG_IDX_W-1:0] cfg_index_i,
  input  logic [rcfe_pkg::AXIS_W-1:0]    cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [23:0]                    s_axis_tdata,  // axis_number[7:0], axis_value[23:8]
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [7:0]                     m_axis_tdata,  // frame_byte[7:0]
  output logic                           m_axis_tlast
);
  import rcfe_pkg::*;

  logic                                 in_valid_q, in_valid_d;
  logic [AXIS_W-1:0]                    in_axis_q;
  logic [VALUE_W-1:0]                   in_value_q;
  logic                                 in_accept;
  logic                                 can_start;
  logic                                 start;
  upd_t                                 upd;
  logic [CHANNEL_COUNT-1:0][CHAN_W-1:0] chan;

  assign start = in_valid_q && can_start;
  assign s_axis_tready = !in_valid_q || can_start;
  assign in_accept = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (start) begin
      in_valid_d = 1'b0;
    end
    if (in_accept) begin
      in_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_axis_q <= s_axis_tdata[AXIS_W-1:0];
      in_value_q <= s_axis_tdata[AXIS_W+VALUE_W-1:AXIS_W];
    end
  end

  assign upd.en = start;
  assign upd.axis = in_axis_q;
  assign upd.value = in_value_q;

  rcfe_chan_bank #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_chan_bank (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i),
    .upd_i      (upd),
    .chan_o     (chan)
  );

  rcfe_framer #(
    .CHANNEL_COUNT(CHANNEL_COUNT)
  ) u_framer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .chan_i     (chan),
    .can_start_o(can_start),
    .valid_o    (m_axis_tvalid),
    .ready_i    (m_axis_tready),
    .byte_o     (m_axis_tdata),
    .last_o     (m_axis_tlast)
  );

endmodule

// ----- verif/tb_rc_channel_frame_encoder_unit.sv -----
// Self-checking testbench for the RC channel frame encoder: axis events in, checked frame bytes out.
module tb_rc_channel_frame_encoder_unit;
  import rcfe_pkg::*;

  localparam int FRAME_BYTES = 6 + 2 * CHANNEL_COUNT_DEF;
  localparam int SETTLE_CYCLES = 3 * FRAME_BYTES;
  localparam int DIRECTED_COUNT = 17;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } frame_beat_t;

  typedef struct packed {
    logic [AXIS_W-1:0]  axis;
    logic [VALUE_W-1:0] value;
    logic               sum_known;
    logic [BYTE_W-1:0]  sum;
  } axis_event_t;

  typedef logic [REG_COUNT-1:0][AXIS_W-1:0] axis_set_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_MASK
  } ready_mode_e;

  // Checksums are typed in where the frame is easy to reckon by hand: all channels at
  // centre gives D8, roll at 1000 gives EA and roll at 1999 gives C9.
  localparam axis_event_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{8'hFF, 16'h0000, 1'b1, 8'hD8},
    '{8'h00, 16'h8000, 1'b1, 8'hEA},
    '{8'h00, 16'h7FFF, 1'b1, 8'hC9},
    '{8'h00, 16'h0000, 1'b1, 8'hD8},
    '{8'h01, 16'hFFFF, 1'b0, 8'h00},
    '{8'h02, 16'h0001, 1'b0, 8'h00},
    '{8'h03, 16'h5555, 1'b0, 8'h00},
    '{8'h04, 16'hAAAA, 1'b0, 8'h00},
    '{8'h05, 16'h7FFF, 1'b0, 8'h00},
    '{8'h06, 16'h8000, 1'b0, 8'h00},
    '{8'h07, 16'h1234, 1'b0, 8'h00},
    '{8'h08, 16'h7FFF, 1'b0, 8'h00},
    '{8'hAA, 16'h5555, 1'b0, 8'h00},
    '{8'h55, 16'hAAAA, 1'b0, 8'h00},
    '{8'h80, 16'hFFFF, 1'b0, 8'h00},
    '{8'h00, 16'hC000, 1'b0, 8'h00},
    '{8'h07, 16'h4000, 1'b0, 8'h00}
  };

  logic                  clk = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [REG_IDX_W-1:0]  cfg_index_i = '0;
  logic [AXIS_W-1:0]     cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [7:0]            m_axis_tdata;
  logic                  m_axis_tlast;

  logic [CHAN_W-1:0]     chan_pos [CHANNEL_COUNT_DEF];
  logic [AXIS_W-1:0]     axis_sel [REG_COUNT];
  frame_beat_t           pending_beats [$];
  int                    fail_count = 0;
  int                    burst_left = 0;
  logic                  sender_steady = 1'b0;

  ready_mode_e           ready_mode = READY_ALWAYS;
  logic [15:0]           ready_mask = 16'hFFFF;
  logic [5:0]            ready_tick = '0;

  rc_channel_frame_encoder_unit #(
    .CHANNEL_COUNT(CHANNEL_COUNT_DEF)
  ) dut (
    .clk_i        (clk),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("[rc_channel_frame_encoder_unit] ERROR");
    $finish;
  end

  // Updates the channel bank for one axis event and queues the 22 bytes of its frame.
  function automatic void encode_frame(input logic [AXIS_W-1:0] axis,
                                       input logic [VALUE_W-1:0] value,
                                       input logic sum_known, input logic [BYTE_W-1:0] typed_sum);
    logic [25:0]       prod;
    logic [BYTE_W-1:0] csum;
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    logic [BYTE_W-1:0] size_byte;
    frame_beat_t       beat;
    bit                hit;
    hit = 1'b0;
    // Adding 32768 to a two's complement position is the same as flipping its top bit.
    prod = {10'd0, ~value[15], value[14:0]} * 26'd1000;
    for (int i = 0; i < CHANNEL_COUNT_DEF; i++) begin
      if (!hit && axis_sel[i] == axis) begin
        chan_pos[i] = BASE_VALUE + {1'b0, prod[25:16]};
        hit = 1'b1;
      end
    end
    size_byte = BYTE_W'(2 * CHANNEL_COUNT_DEF);
    beat.last = 1'b0;
    beat.data = CHAR_DOLLAR; pending_beats.push_back(beat);
    beat.data = CHAR_M;      pending_beats.push_back(beat);
    beat.data = CHAR_LT;     pending_beats.push_back(beat);
    beat.data = size_byte;   pending_beats.push_back(beat);
    beat.data = FRAME_TYPE;  pending_beats.push_back(beat);
    csum = size_byte ^ FRAME_TYPE;
    for (int i = 0; i < CHANNEL_COUNT_DEF; i++) begin
      lo = chan_pos[i][7:0];
      hi = {5'd0, chan_pos[i][10:8]};
      beat.data = lo; pending_beats.push_back(beat);
      beat.data = hi; pending_beats.push_back(beat);
      csum = csum ^ lo ^ hi;
    end
    beat.data = sum_known ? typed_sum : csum;
    beat.last = 1'b1;
    pending_beats.push_back(beat);
  endfunction

  // Offers one event, waits for the transaction, then maybe opens a gap in the stream.
  task automatic send_event(input axis_event_t ev);
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {ev.value, ev.axis};
    do @(posedge clk); while (!s_axis_tready);
    encode_frame(ev.axis, ev.value, ev.sum_known, ev.sum);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (!sender_steady) begin
        repeat ($urandom_range(1, 30)) begin
          @(negedge clk);
          s_axis_tvalid <= 1'b0;
          s_axis_tdata <= 24'($urandom);
        end
      end
    end
    burst_left--;
  endtask

  // Stops sending and waits until every queued frame byte has been seen.
  task automatic drain_frames();
    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic load_axis_map(input axis_set_t map);
    for (int i = 0; i < REG_COUNT; i++) begin
      @(negedge clk);
      cfg_we_i <= 1'b1;
      cfg_index_i <= REG_IDX_W'(i);
      cfg_data_i <= map[i];
      axis_sel[i] = map[i];
    end
    @(negedge clk);
    cfg_we_i <= 1'b0;
  endtask

  // Mostly axes that hit a channel, with the position extremes turning up now and then.
  task automatic run_random(input int count);
    axis_event_t ev;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 3) != 0) ev.axis = axis_sel[$urandom_range(0, REG_COUNT - 1)];
      else ev.axis = AXIS_W'($urandom);
      case ($urandom_range(0, 11))
        0: ev.value = 16'h8000;
        1: ev.value = 16'h7FFF;
        2: ev.value = 16'h0000;
        3: ev.value = 16'hFFFF;
        default: ev.value = VALUE_W'($urandom);
      endcase
      ev.sum_known = 1'b0;
      ev.sum = '0;
      send_event(ev);
    end
  endtask

  always @(negedge clk) begin
    ready_tick <= ready_tick + 6'd1;
    if (ready_tick == '0) begin
      ready_mode <= ready_mode_e'($urandom_range(0, 2));
      ready_mask <= 16'($urandom) | 16'h0101;
    end
    case (ready_mode)
      READY_ALWAYS: m_axis_tready <= 1'b1;
      READY_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
      default:      m_axis_tready <= ready_mask[ready_tick[3:0]];
    endcase
  end

  always @(posedge clk) begin : check_beats
    frame_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_beats.size() == 0) begin
        $error("frame_byte: none expected, actual %02h", m_axis_tdata);
        fail_count++;
      end else begin
        want = pending_beats.pop_front();
        if (m_axis_tdata !== want.data) begin
          $error("frame_byte: expected %02h, actual %02h", want.data, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last_byte: expected %0b, actual %0b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
  end

  initial begin
    axis_set_t map;
    for (int i = 0; i < REG_COUNT; i++) axis_sel[i] = AXIS_W'(i);
    for (int i = 0; i < CHANNEL_COUNT_DEF; i++) chan_pos[i] = CENTRE_VALUE;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_ni <= 1'b1;

    // Reset mapping: each channel follows the axis of its own index.
    for (int i = 0; i < DIRECTED_COUNT; i++) send_event(DIRECTED_ROWS[i]);
    drain_frames();

    // Every channel on the same axis, so only roll may ever move.
    for (int i = 0; i < REG_COUNT; i++) map[i] = 8'hFF;
    load_axis_map(map);
    sender_steady = 1'b1;
    run_random(60);
    drain_frames();

    // Distinct axes at the edges of the range; roll listens to axis 0, pitch to 255.
    map = {8'hAA, 8'h55, 8'h7F, 8'hFE, 8'h01, 8'h80, 8'hFF, 8'h00};
    load_axis_map(map);
    sender_steady = 1'b0;
    run_random(60);
    drain_frames();
    run_random(60);
    drain_frames();

    // Random mapping with frequent repeats among the low axis numbers.
    for (int i = 0; i < REG_COUNT; i++) begin
      if ($urandom_range(0, 1) != 0) map[i] = AXIS_W'($urandom_range(0, 3));
      else map[i] = AXIS_W'($urandom);
    end
    load_axis_map(map);
    run_random(120);
    drain_frames();

    for (int i = 0; i < REG_COUNT; i++) map[i] = AXIS_W'(i);
    load_axis_map(map);
    sender_steady = 1'b1;
    run_random(40);
    sender_steady = 1'b0;
    run_random(80);
    drain_frames();

    if (fail_count == 0) begin
      $display("[rc_channel_frame_encoder_unit] OK");
    end else begin
      $display("[rc_channel_frame_encoder_unit] ERROR");
    end
    $finish;
  end

endmodule

// ----- rc_channel_frame_encoder_unit.f -----
src/rcfe_pkg.sv
src/rcfe_chan_bank.sv
src/rcfe_framer.sv
src/rc_channel_frame_encoder_unit.sv
verif/tb_rc_channel_frame_encoder_unit.sv
